>>> design/rena_pkg.sv
// Shared constants, types and mask helper for the range erase / nearest alive block.
package rena_pkg;

   localparam int MAX_UNITS  = 4096;
   localparam int WORD_W     = 64;
   localparam int IDX_W      = $clog2(WORD_W);
   localparam int WORD_COUNT = (MAX_UNITS + WORD_W - 1) / WORD_W;
   localparam int ADDR_W     = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
   localparam int POS_W      = 13;
   localparam int BOUND_W    = POS_W + 1;
   localparam int CNT_W      = ADDR_W + 1;
   localparam int DIFF_W     = BOUND_W + 2;

   localparam logic OP_REFILL = 1'b0;
   localparam logic OP_REMOVE = 1'b1;

   typedef logic [WORD_W-1:0] word_type;
   typedef logic [ADDR_W-1:0] addr_type;
   typedef logic [POS_W-1:0]  pos_type;

   typedef struct packed {
      logic     has_left;
      pos_type  left_pos;
      logic     has_right;
      pos_type  right_pos;
      word_type cleared;
   } scan_type;

   // bits of word w whose position p = w*WORD_W + b + 1 lies below bound
   function automatic word_type below_mask(addr_type w, logic [BOUND_W-1:0] bound);
      logic signed [DIFF_W-1:0] c;
      word_type m;
      c = $signed(DIFF_W'(bound)) - DIFF_W'(1) - $signed(DIFF_W'({w, IDX_W'(0)}));
      if (c <= 0) begin
         m = '0;
      end else if (c >= DIFF_W'(WORD_W)) begin
         m = '1;
      end else begin
         m = (word_type'(1) << c[IDX_W-1:0]) - word_type'(1);
      end
      return m;
   endfunction

endpackage

>>> design/range_erase_nearest_alive_unit.sv
// Top level: sequencer scanning the presence bitmap one word per cycle.
// Refill beat: accepted with no result; req_tready stays high.
// Removal beat: 64 word reads, one per cycle, each word cleared and written back
//   the cycle after its read; result on rsp after the last word, or from ST_HOLD
//   once rsp is ready; no new beat is taken until the removal is done.
// Reset: synchronous, not ready while held; bitmap empty via valid bits, unit_count 4096.
module range_erase_nearest_alive_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // [12:0] range_low, [25:13] range_high, rest zero
   input  logic [0:0]  req_tuser,  // [0] opcode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,  // [12:0] left_neighbour, [25:13] right_neighbour
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [12:0] csr_data    // unit_count
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_HOLD = 2'd2;

   logic [1:0]                  state_ff, state_in;
   logic [rena_pkg::CNT_W-1:0]  rd_cnt_ff, rd_cnt_in;
   logic                        proc_ff, proc_in;
   rena_pkg::addr_type          proc_addr_ff, proc_addr_in;
   rena_pkg::pos_type           lo_ff, lo_in, hi_ff, hi_in;
   rena_pkg::pos_type           left_ff, left_in, right_ff, right_in;
   logic                        found_ff, found_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [31:0]                 rsp_data_ff, rsp_data_in;
   rena_pkg::pos_type           unit_count_ff, unit_count_in;

   logic                        req_beat, refill, rd_en;
   rena_pkg::word_type          rd_word;
   rena_pkg::scan_type          scan;
   rena_pkg::pos_type           left_fin, right_fin;

   assign req_tready = (state_ff == ST_IDLE) && !reset;
   assign req_beat   = req_tvalid && req_tready;
   assign refill     = req_beat && (req_tuser[0] == rena_pkg::OP_REFILL);
   assign rd_en      = (state_ff == ST_SCAN)
                       && (rd_cnt_ff < rena_pkg::CNT_W'(rena_pkg::WORD_COUNT));
   assign csr_ready  = !reset;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   rena_bitmap u_bitmap (
      .clock      (clock),
      .reset      (reset),
      .refill     (refill),
      .unit_count (unit_count_ff),
      .rd_en      (rd_en),
      .rd_addr    (rd_cnt_ff[rena_pkg::ADDR_W-1:0]),
      .wr_en      (proc_ff),
      .wr_addr    (proc_addr_ff),
      .wr_data    (scan.cleared),
      .rd_word    (rd_word)
   );

   rena_word_unit u_word (
      .word_addr  (proc_addr_ff),
      .word       (rd_word),
      .range_low  (lo_ff),
      .range_high (hi_ff),
      .result     (scan)
   );

   assign left_fin  = scan.has_left ? scan.left_pos : left_ff;
   assign right_fin = (scan.has_right && !found_ff) ? scan.right_pos : right_ff;

   always_comb begin
      state_in      = state_ff;
      rd_cnt_in     = rd_cnt_ff;
      proc_in       = rd_en;
      proc_addr_in  = rd_cnt_ff[rena_pkg::ADDR_W-1:0];
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      left_in       = left_ff;
      right_in      = right_ff;
      found_in      = found_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      unit_count_in = (csr_valid && csr_ready) ? csr_data : unit_count_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_beat && (req_tuser[0] == rena_pkg::OP_REMOVE)) begin
               lo_in     = req_tdata[12:0];
               hi_in     = req_tdata[25:13];
               rd_cnt_in = '0;
               left_in   = '0;
               right_in  = '0;
               found_in  = 1'b0;
               state_in  = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (rd_en) begin
               rd_cnt_in = rd_cnt_ff + rena_pkg::CNT_W'(1);
            end
            if (proc_ff) begin
               left_in  = left_fin;
               right_in = right_fin;
               found_in = found_ff || scan.has_right;
               if (proc_addr_ff == rena_pkg::ADDR_W'(rena_pkg::WORD_COUNT - 1)) begin
                  if (!rsp_valid_ff || rsp_tready) begin
                     rsp_valid_in = 1'b1;
                     rsp_data_in  = {6'd0, right_fin, left_fin};
                     state_in     = ST_IDLE;
                  end else begin
                     state_in = ST_HOLD;
                  end
               end
            end
         end
         ST_HOLD: begin
            if (rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {6'd0, right_ff, left_ff};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rd_cnt_ff     <= '0;
         proc_ff       <= 1'b0;
         found_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         unit_count_ff <= rena_pkg::POS_W'(rena_pkg::MAX_UNITS);
      end else begin
         state_ff      <= state_in;
         rd_cnt_ff     <= rd_cnt_in;
         proc_ff       <= proc_in;
         found_ff      <= found_in;
         rsp_valid_ff  <= rsp_valid_in;
         unit_count_ff <= unit_count_in;
      end
   end

   always_ff @(posedge clock) begin
      proc_addr_ff <= proc_addr_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      left_ff      <= left_in;
      right_ff     <= right_in;
      rsp_data_ff  <= rsp_data_in;
   end

endmodule

>>> design/rena_bitmap.sv
// Presence bitmap memory with per-word valid bits; invalid words read as the refill pattern.
module rena_bitmap (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  refill,
   input  rena_pkg::pos_type     unit_count,
   input  logic                  rd_en,
   input  rena_pkg::addr_type    rd_addr,
   input  logic                  wr_en,
   input  rena_pkg::addr_type    wr_addr,
   input  rena_pkg::word_type    wr_data,
   output rena_pkg::word_type    rd_word
);

   rena_pkg::word_type                 mem [rena_pkg::WORD_COUNT];
   logic [rena_pkg::WORD_COUNT-1:0]    valid_ff, valid_in;
   rena_pkg::pos_type                  fill_n_ff, fill_n_in;
   rena_pkg::word_type                 rd_data_ff;
   logic                               rd_valid_ff;
   rena_pkg::addr_type                 rd_addr_ff;

   always_comb begin
      valid_in  = valid_ff;
      fill_n_in = fill_n_ff;
      if (refill) begin
         valid_in = '0;
         if (unit_count > rena_pkg::POS_W'(rena_pkg::MAX_UNITS)) begin
            fill_n_in = rena_pkg::POS_W'(rena_pkg::MAX_UNITS);
         end else begin
            fill_n_in = unit_count;
         end
      end else if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         fill_n_ff <= '0;
      end else begin
         valid_ff  <= valid_in;
         fill_n_ff <= fill_n_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff  <= mem[rd_addr];
         rd_valid_ff <= valid_ff[rd_addr];
         rd_addr_ff  <= rd_addr;
      end
   end

   assign rd_word = rd_valid_ff ? rd_data_ff
      : rena_pkg::below_mask(rd_addr_ff, rena_pkg::BOUND_W'(fill_n_ff) + rena_pkg::BOUND_W'(1));

endmodule

>>> design/rena_word_unit.sv
// Shared word unit: neighbor search and range clear over one bitmap word.
module rena_word_unit (
   input  rena_pkg::addr_type  word_addr,
   input  rena_pkg::word_type  word,
   input  rena_pkg::pos_type   range_low,
   input  rena_pkg::pos_type   range_high,
   output rena_pkg::scan_type  result
);

   rena_pkg::word_type below_low, below_above, pre_bits, suc_bits;
   logic [rena_pkg::IDX_W-1:0] msb_idx, lsb_idx;

   always_comb begin
      below_low   = rena_pkg::below_mask(word_addr, rena_pkg::BOUND_W'(range_low));
      below_above = rena_pkg::below_mask(word_addr,
                       rena_pkg::BOUND_W'(range_high) + rena_pkg::BOUND_W'(1));
      pre_bits    = word & below_low;
      suc_bits    = word & ~below_above;
      msb_idx = '0;
      for (int b = 0; b < rena_pkg::WORD_W; b++) begin
         if (pre_bits[b]) begin
            msb_idx = rena_pkg::IDX_W'(b);
         end
      end
      lsb_idx = '0;
      for (int b = rena_pkg::WORD_W - 1; b >= 0; b--) begin
         if (suc_bits[b]) begin
            lsb_idx = rena_pkg::IDX_W'(b);
         end
      end
      result.has_left  = |pre_bits;
      result.left_pos  = rena_pkg::POS_W'({word_addr, msb_idx}) + rena_pkg::POS_W'(1);
      result.has_right = |suc_bits;
      result.right_pos = rena_pkg::POS_W'({word_addr, lsb_idx}) + rena_pkg::POS_W'(1);
      result.cleared   = word & ~(~below_low & below_above);
   end

endmodule

>>> design/rena_checker.sv
// Port-level checker for the range erase / nearest alive block, with its bind.
module rena_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [0:0]  req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp beat dropped or changed while stalled");

   a_busy_after_remove: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser[0] == rena_pkg::OP_REMOVE) |=> !req_tready)
      else $error("removal beat did not make the block busy");

   a_refill_silent: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser[0] == rena_pkg::OP_REFILL) && !rsp_tvalid
      |=> !rsp_tvalid)
      else $error("refill beat produced a result");

   a_rsp_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[12:0] <= 13'(rena_pkg::MAX_UNITS))
                     && (rsp_tdata[25:13] <= 13'(rena_pkg::MAX_UNITS))
                     && (rsp_tdata[31:26] == 6'd0))
      else $error("result position out of range");

endmodule

bind range_erase_nearest_alive_unit rena_checker u_rena_checker (.*);

>>> tb/sv/range_erase_nearest_alive_unit_tb.sv
// Testbench for range_erase_nearest_alive_unit: directed table then random beats, bitmap predictor.
`timescale 1ns / 100ps
module range_erase_nearest_alive_unit_tb;

   localparam int SETTLE      = 80;
   localparam int HOLD_AT     = 150;
   localparam int HOLD_CYCLES = 700;
   localparam int PHASE_BEATS = 85;

   // same layout as rsp_tdata[25:0]
   typedef struct packed {
      rena_pkg::pos_type right;
      rena_pkg::pos_type left;
   } neighbours_type;

   typedef struct packed {
      logic              op;
      rena_pkg::pos_type lo;
      rena_pkg::pos_type hi;
      logic              known;
      rena_pkg::pos_type left;
      rena_pkg::pos_type right;
   } plan_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;   // [12:0] range_low, [25:13] range_high
   logic [0:0]  req_tuser = '0;   // [0] opcode
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;        // [12:0] left_neighbour, [25:13] right_neighbour
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [12:0] csr_data = '0;    // unit_count

   bit                occupied [1:rena_pkg::MAX_UNITS];
   rena_pkg::pos_type refill_count = rena_pkg::pos_type'(rena_pkg::MAX_UNITS);
   neighbours_type    neighbour_q [$];
   int                errors, beats_in, refills, results_seen, settings;
   bit                calm;

   plan_row_type plan [19] = '{
      '{rena_pkg::OP_REMOVE, 13'd1,    13'd4096, 1'b1, 13'd0,    13'd0},
      '{rena_pkg::OP_REFILL, 13'd0,    13'd0,    1'b0, 13'd0,    13'd0},
      '{rena_pkg::OP_REMOVE, 13'd100,  13'd200,  1'b1, 13'd99,   13'd201},
      '{rena_pkg::OP_REMOVE, 13'd0,    13'd0,    1'b1, 13'd0,    13'd1},
      '{rena_pkg::OP_REMOVE, 13'd1,    13'd1,    1'b1, 13'd0,    13'd2},
      '{rena_pkg::OP_REMOVE, 13'd4096, 13'd4096, 1'b1, 13'd4095, 13'd0},
      '{rena_pkg::OP_REMOVE, 13'd8191, 13'd8191, 1'b1, 13'd4095, 13'd0},
      '{rena_pkg::OP_REMOVE, 13'd300,  13'd250,  1'b0, 13'd0,    13'd0},
      '{rena_pkg::OP_REMOVE, 13'd150,  13'd150,  1'b0, 13'd0,    13'd0},
      '{rena_pkg::OP_REMOVE, 13'd64,   13'd65,   1'b0, 13'd0,    13'd0},
      '{rena_pkg::OP_REMOVE, 13'd128,  13'd129,  1'b0, 13'd0,    13'd0},
      '{rena_pkg::OP_REMOVE, 13'd4097, 13'd8190, 1'b0, 13'd0,    13'd0},
      '{rena_pkg::OP_REMOVE, 13'd1,    13'd0,    1'b0, 13'd0,    13'd0},
      '{rena_pkg::OP_REMOVE, 13'd0,    13'd8191, 1'b0, 13'd0,    13'd0},
      '{rena_pkg::OP_REMOVE, 13'd2000, 13'd3000, 1'b1, 13'd0,    13'd0},
      '{rena_pkg::OP_REFILL, 13'd0,    13'd0,    1'b0, 13'd0,    13'd0},
      '{rena_pkg::OP_REMOVE, 13'd2,    13'd4095, 1'b0, 13'd0,    13'd0},
      '{rena_pkg::OP_REMOVE, 13'd4095, 13'd4094, 1'b0, 13'd0,    13'd0},
      '{rena_pkg::OP_REMOVE, 13'd5461, 13'd2730, 1'b0, 13'd0,    13'd0}
   };

   rena_pkg::pos_type unit_plan [8] =
      '{13'd1, 13'd0, 13'd8191, 13'd64, 13'd65, 13'd4095, 13'd700, 13'd4096};

   range_erase_nearest_alive_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic void refill_map();
      int p;
      for (p = 1; p <= rena_pkg::MAX_UNITS; p++) occupied[p] = (p <= refill_count);
   endfunction

   function automatic void predict_neighbours(input rena_pkg::pos_type lo,
                                              input rena_pkg::pos_type hi,
                                              output neighbours_type found);
      int p, top, first, last;
      found = '0;
      top = (lo > rena_pkg::MAX_UNITS) ? rena_pkg::MAX_UNITS : int'(lo) - 1;
      for (p = top; p >= 1 && found.left == 0; p--)
         if (occupied[p]) found.left = rena_pkg::pos_type'(p);
      for (p = int'(hi) + 1; p <= rena_pkg::MAX_UNITS && found.right == 0; p++)
         if (occupied[p]) found.right = rena_pkg::pos_type'(p);
      first = (lo == 0) ? 1 : int'(lo);
      last  = (hi > rena_pkg::MAX_UNITS) ? rena_pkg::MAX_UNITS : int'(hi);
      for (p = first; p <= last; p++) occupied[p] = 1'b0;
   endfunction

   task automatic send_beat(input logic op, input rena_pkg::pos_type lo,
                            input rena_pkg::pos_type hi, input logic known,
                            input rena_pkg::pos_type left, input rena_pkg::pos_type right);
      int gap;
      neighbours_type want;
      gap = calm ? 0 : $urandom_range(0, 10);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {6'b0, hi, lo};
      do @(posedge clock); while (!req_tready);
      beats_in++;
      if (op == rena_pkg::OP_REFILL) begin
         refill_map();
         refills++;
      end else begin
         predict_neighbours(lo, hi, want);
         if (known) begin
            want.left  = left;
            want.right = right;
         end
         neighbour_q.insert(neighbour_q.size(), want);
      end
   endtask

   task automatic drain_and_settle();
      req_tvalid <= 1'b0;
      while (neighbour_q.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_unit_count(input rena_pkg::pos_type value);
      drain_and_settle();
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      refill_count = value;
      settings++;
   endtask

   task automatic random_beat();
      int reach, pick, lo, hi;
      reach = (refill_count == 0) ? 1 :
              (refill_count > rena_pkg::MAX_UNITS) ? rena_pkg::MAX_UNITS : int'(refill_count);
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
         send_beat(rena_pkg::OP_REFILL, '0, '0, 1'b0, '0, '0);
      end else begin
         if (pick < 20) begin
            lo = $urandom_range(0, 8191);
            hi = $urandom_range(0, 8191);
         end else if (pick < 30) begin
            hi = $urandom_range(1, reach);
            lo = hi + $urandom_range(1, 40);
         end else begin
            lo = $urandom_range(1, reach);
            if ($urandom_range(0, 3) != 0) hi = lo + $urandom_range(0, reach / 32 + 2);
            else hi = lo + $urandom_range(0, reach);
            if (hi > rena_pkg::MAX_UNITS) hi = rena_pkg::MAX_UNITS;
         end
         send_beat(rena_pkg::OP_REMOVE, rena_pkg::pos_type'(lo), rena_pkg::pos_type'(hi),
                   1'b0, '0, '0);
      end
   endtask

   initial begin : drain_rsp
      neighbours_type got, want;
      int gap;
      do @(posedge clock); while (reset);
      rsp_tready <= 1'b1;
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[25:0];
            if (neighbour_q.size() == 0) begin
               $error("unexpected result beat: left_neighbour %0d, right_neighbour %0d",
                      got.left, got.right);
               errors++;
            end else begin
               want = neighbour_q.pop_front();
               if (got.left !== want.left) begin
                  $error("left_neighbour: expected %0d, got %0d", want.left, got.left);
                  errors++;
               end
               if (got.right !== want.right) begin
                  $error("right_neighbour: expected %0d, got %0d", want.right, got.right);
                  errors++;
               end
            end
            results_seen++;
            // one long hold-off so the block backs up into its input
            if (results_seen == HOLD_AT) gap = HOLD_CYCLES;
            else gap = calm ? 0 : $urandom_range(0, 10);
            if (gap != 0) begin
               rsp_tready <= 1'b0;
               if (gap <= 10 && $urandom_range(0, 1) == 1)
                  do @(posedge clock); while (!rsp_tvalid);
               repeat (gap) @(posedge clock);
               rsp_tready <= 1'b1;
            end
         end
      end
   end

   initial begin : stimulus
      int i, k;
      unit_plan[6] = rena_pkg::pos_type'($urandom_range(2, 4095));
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      for (i = 0; i < 19; i++)
         send_beat(plan[i].op, plan[i].lo, plan[i].hi, plan[i].known, plan[i].left,
                   plan[i].right);
      for (k = 0; k < 8; k++) begin
         write_unit_count(unit_plan[k]);
         calm = (k % 3 == 2);
         send_beat(rena_pkg::OP_REFILL, '0, '0, 1'b0, '0, '0);
         repeat (PHASE_BEATS) random_beat();
      end
      drain_and_settle();
      $display("Covered %0d request beats (%0d refills) and %0d neighbour results",
               beats_in, refills, results_seen);
      $display("over %0d unit_count settings including zero, one and out of range", settings);
      if (errors == 0) begin
         $display("PASS range_erase_nearest_alive_unit");
      end else begin
         $display("FAIL range_erase_nearest_alive_unit");
      end
      $finish;
   end

   initial begin : watchdog
      #5000000;
      $display("FAIL range_erase_nearest_alive_unit");
      $finish;
   end

endmodule
